/* hdl/rwl_arb_pkg.sv */
// Package for the readers-writer lock arbiter: command, result kind and state codes,
// and the default sizes of the task identifier and the wait queues.
// No dependencies.
package rwl_arb_pkg;

  localparam int TASK_ID_BITS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF  = 16;

  localparam int TASK_W   = 8;
  localparam int READER_W = 9;
  localparam int NEST_W   = 8;

  localparam logic [READER_W-1:0] READER_MAX = 9'd511;
  localparam logic [NEST_W-1:0]   NEST_MAX   = 8'd255;

  typedef enum logic [1:0] {
    CMD_ACQ_READ  = 2'd0,
    CMD_REL_READ  = 2'd1,
    CMD_ACQ_WRITE = 2'd2,
    CMD_REL_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    K_DONE    = 2'd0,
    K_QUEUED  = 2'd1,
    K_GRANTED = 2'd2,
    K_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GRANT_W,
    ST_DRAIN_R
  } state_t;

endpackage

/* hdl/readers_writer_lock_arbiter.sv */
// Top level of the writer-preferring readers-writer lock arbiter.
// Holds both wait queues as synchronous memories; depends on rwl_arb_pkg.
//
// Channel  Dir  tdata (low bit up)  tuser        tlast
// in_      in   task_req[7:0]       command[1:0] -
// out_     out  task_out[7:0]       kind[1:0]    last
//
// A request whose only result is the requester's own leaves the arbiter idle,
// and the next request may follow in the next cycle unless the output stalls.
// A request that grants waiters moves to a grant state that issues the grants
// one by one from the registered read of the wait queue memory, taking no request.
// A stalled output register holds the result and blocks new requests.
// Reset clears the lock state and both queue pointers; queue contents stay
// undefined and are read only where written.
module readers_writer_lock_arbiter #(
  parameter int TASK_ID_BITS = rwl_arb_pkg::TASK_ID_BITS_DEF,
  parameter int QUEUE_DEPTH  = rwl_arb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rwl_arb_pkg::TASK_W-1:0] in_tdata,   // task_req[7:0]
  input  logic [1:0]                     in_tuser,   // command[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rwl_arb_pkg::TASK_W-1:0] out_tdata,  // task_out[7:0]
  output logic [1:0]                     out_tuser,  // kind[1:0]
  output logic                           out_tlast
);
  import rwl_arb_pkg::*;

  localparam int TW = TASK_ID_BITS;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  logic [TW-1:0] rmem [QUEUE_DEPTH];
  logic [TW-1:0] wmem [QUEUE_DEPTH];

  state_t              state_r, state_nxt;
  logic [READER_W-1:0] rtotal_r, rtotal_nxt;
  logic                own_v_r, own_v_nxt;
  logic [TW-1:0]       own_task_r, own_task_nxt;
  logic [NEST_W-1:0]   nest_r, nest_nxt;
  logic [PW-1:0]       rhead_r, rhead_nxt, rtail_r, rtail_nxt;
  logic [PW-1:0]       whead_r, whead_nxt, wtail_r, wtail_nxt;
  logic [CW-1:0]       rcnt_r, rcnt_nxt, wcnt_r, wcnt_nxt;
  logic                out_v_r, out_v_nxt;
  logic [TASK_W-1:0]   out_task_r, out_task_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic                out_last_r, out_last_nxt;
  logic [TW-1:0]       rdata_r, wdata_r;

  logic          r_push, w_push;
  logic          can_load, accept, is_owner;
  logic [TW-1:0] task_in;
  cmd_t          cmd_in;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign task_in  = TW'(in_tdata);
  assign cmd_in   = cmd_t'(in_tuser);
  assign can_load = !out_v_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && can_load;
  assign accept   = in_tvalid && in_tready;
  assign is_owner = own_v_r && (own_task_r == task_in);

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_task_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    rtotal_nxt   = rtotal_r;
    own_v_nxt    = own_v_r;
    own_task_nxt = own_task_r;
    nest_nxt     = nest_r;
    rhead_nxt    = rhead_r;
    rtail_nxt    = rtail_r;
    rcnt_nxt     = rcnt_r;
    whead_nxt    = whead_r;
    wtail_nxt    = wtail_r;
    wcnt_nxt     = wcnt_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_task_nxt = out_task_r;
    out_kind_nxt = out_kind_r;
    out_last_nxt = out_last_r;
    r_push       = 1'b0;
    w_push       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_v_nxt    = 1'b1;
          out_task_nxt = TASK_W'(task_in);
          out_last_nxt = 1'b1;
          out_kind_nxt = K_ERROR;
          case (cmd_in)
            CMD_ACQ_READ, CMD_ACQ_WRITE: begin
              if (is_owner) begin
                if (nest_r != NEST_MAX) begin
                  nest_nxt     = nest_r + 1'b1;
                  out_kind_nxt = K_DONE;
                end
              end else if (cmd_in == CMD_ACQ_READ) begin
                if (!own_v_r && wcnt_r == '0) begin
                  if (rtotal_r != READER_MAX) begin
                    rtotal_nxt   = rtotal_r + 1'b1;
                    out_kind_nxt = K_DONE;
                  end
                end else if (rcnt_r != CNT_FULL) begin
                  r_push       = 1'b1;
                  rtail_nxt    = ptr_inc(rtail_r);
                  rcnt_nxt     = rcnt_r + 1'b1;
                  out_kind_nxt = K_QUEUED;
                end
              end else begin
                if (!own_v_r && rtotal_r == '0) begin
                  own_v_nxt    = 1'b1;
                  own_task_nxt = task_in;
                  nest_nxt     = NEST_W'(1);
                  out_kind_nxt = K_DONE;
                end else if (wcnt_r != CNT_FULL) begin
                  w_push       = 1'b1;
                  wtail_nxt    = ptr_inc(wtail_r);
                  wcnt_nxt     = wcnt_r + 1'b1;
                  out_kind_nxt = K_QUEUED;
                end
              end
            end
            CMD_REL_READ: begin
              if (is_owner) begin
                if (nest_r > NEST_W'(1)) begin
                  nest_nxt     = nest_r - 1'b1;
                  out_kind_nxt = K_DONE;
                end
              end else if (rtotal_r != '0) begin
                rtotal_nxt   = rtotal_r - 1'b1;
                out_kind_nxt = K_DONE;
                if (rtotal_r == READER_W'(1) && !own_v_r && wcnt_r != '0) begin
                  out_last_nxt = 1'b0;
                  state_nxt    = ST_GRANT_W;
                end
              end
            end
            default: begin
              if (is_owner && nest_r != '0) begin
                nest_nxt     = nest_r - 1'b1;
                out_kind_nxt = K_DONE;
                if (nest_r == NEST_W'(1)) begin
                  own_v_nxt    = 1'b0;
                  own_task_nxt = '0;
                  if (wcnt_r != '0) begin
                    out_last_nxt = 1'b0;
                    state_nxt    = ST_GRANT_W;
                  end else if (rcnt_r != '0 && rtotal_r != READER_MAX) begin
                    out_last_nxt = 1'b0;
                    state_nxt    = ST_DRAIN_R;
                  end
                end
              end
            end
          endcase
        end
      end
      ST_GRANT_W: begin
        if (can_load) begin
          out_v_nxt    = 1'b1;
          out_task_nxt = TASK_W'(wdata_r);
          out_kind_nxt = K_GRANTED;
          out_last_nxt = 1'b1;
          own_v_nxt    = 1'b1;
          own_task_nxt = wdata_r;
          nest_nxt     = NEST_W'(1);
          whead_nxt    = ptr_inc(whead_r);
          wcnt_nxt     = wcnt_r - 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_DRAIN_R: begin
        if (can_load) begin
          out_v_nxt    = 1'b1;
          out_task_nxt = TASK_W'(rdata_r);
          out_kind_nxt = K_GRANTED;
          out_last_nxt = (rcnt_r == CW'(1)) || (rtotal_r == READER_MAX - 1'b1);
          rtotal_nxt   = rtotal_r + 1'b1;
          rhead_nxt    = ptr_inc(rhead_r);
          rcnt_nxt     = rcnt_r - 1'b1;
          if (out_last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The queue heads are read at their next value, so the read register holds
  // the current head entry in the cycle after a pop.
  always_ff @(posedge clk) begin
    if (r_push) begin
      rmem[rtail_r] <= task_in;
    end
    if (w_push) begin
      wmem[wtail_r] <= task_in;
    end
    rdata_r <= rmem[rhead_nxt];
    wdata_r <= wmem[whead_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rtotal_r   <= '0;
      own_v_r    <= 1'b0;
      own_task_r <= '0;
      nest_r     <= '0;
      rhead_r    <= '0;
      rtail_r    <= '0;
      rcnt_r     <= '0;
      whead_r    <= '0;
      wtail_r    <= '0;
      wcnt_r     <= '0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rtotal_r   <= rtotal_nxt;
      own_v_r    <= own_v_nxt;
      own_task_r <= own_task_nxt;
      nest_r     <= nest_nxt;
      rhead_r    <= rhead_nxt;
      rtail_r    <= rtail_nxt;
      rcnt_r     <= rcnt_nxt;
      whead_r    <= whead_nxt;
      wtail_r    <= wtail_nxt;
      wcnt_r     <= wcnt_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_task_r <= out_task_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  a_grant_no_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GRANT_W) |-> (!own_v_r && wcnt_r != '0))
    else $error("writer grant pending while an owner holds the lock");

  a_drain_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN_R) |-> (!own_v_r && wcnt_r == '0 && rcnt_r != '0))
    else $error("reader drain with an owner, a waiting writer or no reader");

  a_owner_depth: assert property (@(posedge clk) disable iff (!rst_n)
    own_v_r |-> (nest_r != '0))
    else $error("owner present with zero nesting depth");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rcnt_r <= CNT_FULL) && (wcnt_r <= CNT_FULL))
    else $error("wait queue count beyond depth");

  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!out_v_r || out_tready))
    else $error("request taken while the output register is blocked");

endmodule

/* test/tb.sv */
// Self-checking testbench for readers_writer_lock_arbiter: directed lock scenarios,
// queue-full limits, output back-pressure and random traffic.
// Depends on rwl_arb_pkg and the readers_writer_lock_arbiter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwl_arb_pkg::*;

  typedef struct packed {
    logic [TASK_W-1:0] tid;
    kind_t             kind;
    logic              last;
  } lock_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [TASK_W-1:0] in_tdata;
  logic [1:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [TASK_W-1:0] out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;

  // Expected results in arrival order, and the lock state that produces them.
  lock_result_t      lock_results[$];
  lock_result_t      want_r;
  logic [READER_W-1:0] readers_held;
  logic              owner_on;
  logic [TASK_W-1:0] owner_id;
  logic [NEST_W-1:0] owner_depth;
  logic [TASK_W-1:0] read_waiters[$];
  logic [TASK_W-1:0] write_waiters[$];

  bit gaps_on;
  int stall_len;
  int mismatches;
  int items_sent;
  int results_seen;
  int grants_seen;

  readers_writer_lock_arbiter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("readers_writer_lock_arbiter: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 30) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  function automatic void post(logic [TASK_W-1:0] tid, kind_t kind);
    lock_result_t r;
    r.tid  = tid;
    r.kind = kind;
    r.last = 1'b0;
    lock_results.push_back(r);
  endfunction

  function automatic void grant_next_writer();
    owner_id    = write_waiters.pop_front();
    owner_on    = 1'b1;
    owner_depth = NEST_W'(1);
    post(owner_id, K_GRANTED);
  endfunction

  function automatic void predict_lock(cmd_t cmd, logic [TASK_W-1:0] tid);
    logic         mine;
    logic [TASK_W-1:0] rd;
    lock_result_t r;
    mine = owner_on && owner_id == tid;
    case (cmd)
      CMD_ACQ_READ, CMD_ACQ_WRITE: begin
        if (mine) begin
          if (owner_depth >= NEST_MAX) begin
            post(tid, K_ERROR);
          end else begin
            owner_depth++;
            post(tid, K_DONE);
          end
        end else if (cmd == CMD_ACQ_READ) begin
          if (!owner_on && write_waiters.size() == 0) begin
            if (readers_held >= READER_MAX) begin
              post(tid, K_ERROR);
            end else begin
              readers_held++;
              post(tid, K_DONE);
            end
          end else if (read_waiters.size() >= QUEUE_DEPTH_DEF) begin
            post(tid, K_ERROR);
          end else begin
            read_waiters.push_back(tid);
            post(tid, K_QUEUED);
          end
        end else begin
          if (!owner_on && readers_held == 0) begin
            owner_on    = 1'b1;
            owner_id    = tid;
            owner_depth = NEST_W'(1);
            post(tid, K_DONE);
          end else if (write_waiters.size() >= QUEUE_DEPTH_DEF) begin
            post(tid, K_ERROR);
          end else begin
            write_waiters.push_back(tid);
            post(tid, K_QUEUED);
          end
        end
      end
      CMD_REL_READ: begin
        if (mine) begin
          if (owner_depth <= 1) begin
            post(tid, K_ERROR);
          end else begin
            owner_depth--;
            post(tid, K_DONE);
          end
        end else if (readers_held == 0) begin
          post(tid, K_ERROR);
        end else begin
          readers_held--;
          post(tid, K_DONE);
          if (readers_held == 0 && !owner_on && write_waiters.size() > 0) begin
            grant_next_writer();
          end
        end
      end
      default: begin
        if (!mine || owner_depth == 0) begin
          post(tid, K_ERROR);
        end else begin
          owner_depth--;
          post(tid, K_DONE);
          if (owner_depth == 0) begin
            owner_on = 1'b0;
            owner_id = '0;
            if (write_waiters.size() > 0) begin
              grant_next_writer();
            end else begin
              while (read_waiters.size() > 0 && readers_held < READER_MAX) begin
                rd = read_waiters.pop_front();
                readers_held++;
                post(rd, K_GRANTED);
              end
            end
          end
        end
      end
    endcase
    r = lock_results.pop_back();
    r.last = 1'b1;
    lock_results.push_back(r);
  endfunction

  task automatic send_item(cmd_t cmd, logic [TASK_W-1:0] tid);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= tid;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    predict_lock(cmd, tid);
    items_sent++;
  endtask

  task automatic wait_idle();
    int spin;
    spin = 0;
    @(negedge clk) in_tvalid <= 1'b0;
    while (lock_results.size() != 0 && spin < 100000) begin
      @(posedge clk);
      spin++;
    end
    if (lock_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", lock_results.size()));
    end
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (lock_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result task %0h kind %0d last %0b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        want_r = lock_results.pop_front();
        if (want_r.kind == K_GRANTED) grants_seen++;
        if (out_tdata !== want_r.tid) begin
          report_mismatch($sformatf("task %0h, expected %0h", out_tdata, want_r.tid));
        end
        if (out_tuser !== want_r.kind) begin
          report_mismatch($sformatf("kind %0d for task %0h, expected %s",
                                    out_tuser, want_r.tid, want_r.kind.name()));
        end
        if (out_tlast !== want_r.last) begin
          report_mismatch($sformatf("last %0b for task %0h, expected %0b",
                                    out_tlast, want_r.tid, want_r.last));
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_len != 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(negedge clk);
        stall_len = 0;
        out_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic test_lock_basics();
    send_item(CMD_ACQ_READ, 8'h00);
    send_item(CMD_ACQ_READ, 8'hFF);
    send_item(CMD_ACQ_WRITE, 8'hA5);
    send_item(CMD_ACQ_READ, 8'h5A);
    send_item(CMD_REL_READ, 8'h00);
    send_item(CMD_REL_READ, 8'hFF);
    send_item(CMD_REL_WRITE, 8'h11);
    send_item(CMD_ACQ_READ, 8'hA5);
    send_item(CMD_REL_READ, 8'hA5);
    send_item(CMD_REL_READ, 8'hA5);
    send_item(CMD_REL_WRITE, 8'hA5);
    send_item(CMD_REL_READ, 8'h5A);
    send_item(CMD_REL_READ, 8'h5A);
    send_item(CMD_REL_WRITE, 8'h00);
    send_item(CMD_ACQ_WRITE, 8'h33);
    send_item(CMD_ACQ_READ, 8'h44);
    send_item(CMD_ACQ_READ, 8'h44);
    send_item(CMD_ACQ_WRITE, 8'h33);
    send_item(CMD_REL_WRITE, 8'h33);
    send_item(CMD_REL_WRITE, 8'h33);
    send_item(CMD_REL_READ, 8'h44);
    send_item(CMD_REL_READ, 8'h44);
  endtask

  task automatic test_queue_limits();
    logic [TASK_W-1:0] tid;
    send_item(CMD_ACQ_WRITE, 8'hC3);
    for (int i = 0; i <= QUEUE_DEPTH_DEF; i++) begin
      tid = 8'h10 + i[7:0];
      send_item(CMD_ACQ_READ, tid);
    end
    for (int i = 0; i <= QUEUE_DEPTH_DEF; i++) begin
      tid = 8'h80 + i[7:0];
      send_item(CMD_ACQ_WRITE, tid);
    end
    send_item(CMD_REL_WRITE, 8'hC3);
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      tid = 8'h80 + i[7:0];
      send_item(CMD_REL_WRITE, tid);
    end
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      tid = 8'h10 + i[7:0];
      send_item(CMD_REL_READ, tid);
    end
  endtask

  task automatic random_item();
    int   roll;
    cmd_t cmd;
    logic [TASK_W-1:0] tid;
    roll = $urandom_range(0, 99);
    if (roll < 30) cmd = CMD_ACQ_READ;
    else if (roll < 55) cmd = CMD_REL_READ;
    else if (roll < 75) cmd = CMD_ACQ_WRITE;
    else cmd = CMD_REL_WRITE;
    if ($urandom_range(0, 4) == 0) tid = TASK_W'($urandom_range(0, 255));
    else tid = TASK_W'($urandom_range(0, 7));
    if (owner_on) begin
      if (cmd == CMD_REL_WRITE && $urandom_range(0, 9) < 8) tid = owner_id;
      else if (cmd != CMD_REL_WRITE && $urandom_range(0, 4) == 0) tid = owner_id;
    end
    send_item(cmd, tid);
  endtask

  task automatic test_output_stall();
    gaps_on   = 1'b0;
    stall_len = 200;
    repeat (40) random_item();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      random_item();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_ACQ_READ;
    gaps_on      = 1'b1;
    stall_len    = 0;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    grants_seen  = 0;
    readers_held = '0;
    owner_on     = 1'b0;
    owner_id     = '0;
    owner_depth  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_lock_basics();
    wait_idle();
    test_queue_limits();
    wait_idle();
    test_output_stall();
    test_random_traffic(240);
    wait_idle();
    gaps_on = 1'b0;
    test_random_traffic(40);
    wait_idle();

    $display("Sent %0d lock requests and checked %0d results, %0d of them grants.",
             items_sent, results_seen, grants_seen);
    $display("Covered lock hand-off, full wait queues, nested owners and output stalls.");
    if (mismatches == 0) begin
      $display("readers_writer_lock_arbiter: match");
    end else begin
      $display("readers_writer_lock_arbiter: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rwl_arb_pkg.sv
hdl/readers_writer_lock_arbiter.sv
test/tb.sv
